[hw/rtl/sprite_batch_slot_allocator_assert.svh]
// Assertion macros used by the sprite batch slot allocator datapath.
`ifndef SPRITE_BATCH_SLOT_ALLOCATOR_ASSERT_SVH
`define SPRITE_BATCH_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define SBSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define SBSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sbsa_pkg.sv]
// Package: types, codes and constants of the sprite batch slot allocator.
`timescale 1ns / 1ps
package sbsa_pkg;

  // default sizes
  localparam int unsigned LAYERS_DEF    = 8;
  localparam int unsigned BATCHES_DEF   = 16;
  localparam int unsigned SLOTS_DEF     = 4096;
  localparam int unsigned TEX_UNITS_DEF = 32;

  // fixed field widths
  localparam int unsigned LAYER_W     = 3;
  localparam int unsigned TEX_W       = 8;
  localparam int unsigned BATCH_OUT_W = 4;
  localparam int unsigned SLOT_OUT_W  = 12;
  localparam int unsigned UNIT_OUT_W  = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned LCNT_W      = 4;

  localparam logic [LCNT_W-1:0] LCNT_RESET = LCNT_W'(1);

  typedef enum logic [0:0] {
    OP_PLACE = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED    = 2'd0,
    ST_BAD_LAYER = 2'd1,
    ST_NO_BATCH  = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic res_bad;
    logic search_start;
    logic search;
    logic commit;
    logic out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic bad_layer;
    logic need_search;
    logic search_done;
    logic out_free;
  } dp_status_t;

endpackage

[hw/rtl/sprite_batch_slot_allocator.sv]
// Top level of the sprite batch slot allocator: controller, datapath and port wiring.
`timescale 1ns / 1ps
// Sequence: a place beat is captured, checked, searched for its texture among the units bound
//   in its layer's current batch (one RAM read per unit, stopping at a hit), committed and
//   loaded into the output register; the search is skipped if no unit is bound or the batch
//   is full, and a bad layer goes straight to the result. A clear returns to idle after its
//   check. A new beat is taken only once the last one's result is loaded or its clear is done.
// Reset: layer_count is 1, all per-layer batch state is zero; the texture RAM is not cleared.
module sprite_batch_slot_allocator import sbsa_pkg::*; #(
  parameter int unsigned LAYERS    = LAYERS_DEF,
  parameter int unsigned BATCHES   = BATCHES_DEF,
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned TEX_UNITS = TEX_UNITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration: layer_count
  input  logic                   cfg_we_i,
  input  logic [LCNT_W-1:0]      cfg_wdata_i,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   opcode_i,
  input  logic [LAYER_W-1:0]     layer_i,
  input  logic [TEX_W-1:0]       tex_id_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [BATCH_OUT_W-1:0] batch_o,
  output logic [SLOT_OUT_W-1:0]  slot_o,
  output logic [UNIT_OUT_W-1:0]  tex_unit_o,
  output logic                   batch_created_o,
  output logic [STATUS_W-1:0]    status_o
);

  // Only the current batch of each layer is ever touched: batches past it are
  // empty by construction, so the datapath keeps one slot count, one unit
  // count and one row of bound texture ids per layer. Moving to the next batch
  // simply restarts those counts.

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // The controller takes one beat at a time; the result is parked in an
  // output register so the next beat can be taken while it waits.
  sbsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (dp_status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  sbsa_dp #(
    .LAYERS    (LAYERS),
    .BATCHES   (BATCHES),
    .SLOTS     (SLOTS),
    .TEX_UNITS (TEX_UNITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .layer_i         (layer_i),
    .tex_id_i        (tex_id_i),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .batch_o         (batch_o),
    .slot_o          (slot_o),
    .tex_unit_o      (tex_unit_o),
    .batch_created_o (batch_created_o),
    .status_out_o    (status_o)
  );

endmodule

[hw/rtl/sbsa_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module sbsa_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sbsa_ctrl.sv]
// Controller state machine: sequences capture, lookup, clear, unit search, commit and result.
`timescale 1ns / 1ps
module sbsa_ctrl import sbsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SEARCH = 5'b00100,
    S_COMMIT = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end else if (status_i.bad_layer) begin
          cmd_o.res_bad = 1'b1;
          state_d       = S_RESULT;
        end else if (status_i.need_search) begin
          cmd_o.search_start = 1'b1;
          state_d            = S_SEARCH;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (status_i.search_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/sbsa_dp.sv]
// Datapath: per-layer batch state, texture unit RAM, search, result and output registers.
`timescale 1ns / 1ps
`include "sprite_batch_slot_allocator_assert.svh"
module sbsa_dp import sbsa_pkg::*; #(
  parameter int unsigned LAYERS    = LAYERS_DEF,
  parameter int unsigned BATCHES   = BATCHES_DEF,
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned TEX_UNITS = TEX_UNITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LCNT_W-1:0]      cfg_wdata_i,
  input  logic                   opcode_i,
  input  logic [LAYER_W-1:0]     layer_i,
  input  logic [TEX_W-1:0]       tex_id_i,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             status_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [BATCH_OUT_W-1:0] batch_o,
  output logic [SLOT_OUT_W-1:0]  slot_o,
  output logic [UNIT_OUT_W-1:0]  tex_unit_o,
  output logic                   batch_created_o,
  output logic [STATUS_W-1:0]    status_out_o
);

  localparam int unsigned LIW   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int unsigned ACW   = ($clog2(LAYERS + 1) > LCNT_W) ? $clog2(LAYERS + 1) : LCNT_W;
  localparam int unsigned BW    = (BATCHES > 1) ? $clog2(BATCHES) : 1;
  localparam int unsigned CRW   = $clog2(BATCHES + 1);
  localparam int unsigned SCW   = $clog2(SLOTS + 1);
  localparam int unsigned UIW   = (TEX_UNITS > 1) ? $clog2(TEX_UNITS) : 1;
  localparam int unsigned UCW   = $clog2(TEX_UNITS + 1);
  localparam int unsigned DEPTH = LAYERS * TEX_UNITS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [LCNT_W-1:0] lcnt_q;
  logic [ACW-1:0]    active;

  // captured beat
  opcode_e            op_q;
  logic [LAYER_W-1:0] layer_q;
  logic [TEX_W-1:0]   tex_q;

  // per-layer state of the current batch
  logic [BW-1:0]  cur_q     [LAYERS];
  logic [CRW-1:0] created_q [LAYERS];
  logic [SCW-1:0] slots_q   [LAYERS];
  logic [UCW-1:0] units_q   [LAYERS];

  logic [LIW-1:0] layer_idx;
  logic [BW-1:0]  cur_rd;
  logic [CRW-1:0] created_rd;
  logic [SCW-1:0] slots_rd;
  logic [UCW-1:0] units_rd;
  logic           bad_layer;
  logic           slots_ok;

  // search
  logic [UCW-1:0]   rd_idx_q;
  logic             rd_vld_q;
  logic [UIW-1:0]   cmp_idx_q;
  logic             hit_q;
  logic [UIW-1:0]   hit_idx_q;
  logic             issue;
  logic             match;
  logic [TEX_W-1:0] ram_rdata;
  logic [AW-1:0]    base;

  // placement decision
  logic           made0;
  logic [CRW-1:0] created_eff;
  logic           fits;
  logic [CRW-1:0] nxt;
  logic           need_new;
  logic           no_batch;
  logic [BW-1:0]  new_batch;
  logic [CRW-1:0] new_created;
  logic           made;
  logic [UIW-1:0] unit;
  logic           is_new;
  logic [SCW-1:0] slot;
  logic [UCW-1:0] new_units;
  logic           commit_ok;
  logic           ram_we;

  // pending result and output register
  logic [BATCH_OUT_W-1:0] res_batch_q, out_batch_q;
  logic [SLOT_OUT_W-1:0]  res_slot_q, out_slot_q;
  logic [UNIT_OUT_W-1:0]  res_unit_q, out_unit_q;
  logic                   res_made_q, out_made_q;
  status_e                res_status_q, out_status_q;
  logic                   out_valid_q;
  logic                   out_free;

  assign active = (ACW'(lcnt_q) > ACW'(LAYERS)) ? ACW'(LAYERS) : ACW'(lcnt_q);

  assign layer_idx  = LIW'(layer_q);
  assign cur_rd     = cur_q[layer_idx];
  assign created_rd = created_q[layer_idx];
  assign slots_rd   = slots_q[layer_idx];
  assign units_rd   = units_q[layer_idx];
  assign bad_layer  = ACW'(layer_q) >= active;
  assign slots_ok   = slots_rd < SCW'(SLOTS);

  assign base  = AW'(layer_idx) * AW'(TEX_UNITS);
  assign issue = cmd_i.search && (rd_idx_q < units_rd);
  assign match = rd_vld_q && (ram_rdata == tex_q);

  // an untouched layer behaves as if batch 0 already existed
  assign made0       = (created_rd == '0);
  assign created_eff = made0 ? CRW'(1) : created_rd;
  assign fits        = slots_ok && (hit_q || (units_rd < UCW'(TEX_UNITS)));
  assign nxt         = CRW'(cur_rd) + CRW'(1);
  assign need_new    = !fits && (nxt >= created_eff);
  assign no_batch    = need_new && (created_eff >= CRW'(BATCHES));
  assign new_batch   = fits ? cur_rd : BW'(nxt);
  assign new_created = need_new ? created_eff + CRW'(1) : created_eff;
  assign made        = made0 || need_new;
  assign unit        = !fits ? '0 : (hit_q ? hit_idx_q : UIW'(units_rd));
  assign is_new      = !fits || !hit_q;
  assign slot        = fits ? slots_rd : '0;
  assign new_units   = is_new ? UCW'(unit) + UCW'(1) : units_rd;
  assign commit_ok   = cmd_i.commit && !no_batch;
  assign ram_we      = commit_ok && is_new;

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.is_clear    = (op_q == OP_CLEAR);
  assign status_o.bad_layer   = bad_layer;
  assign status_o.need_search = slots_ok && (units_rd != '0);
  assign status_o.search_done = rd_vld_q && (match || ((UCW'(cmp_idx_q) + UCW'(1)) == units_rd));
  assign status_o.out_free    = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q <= LCNT_RESET;
    end else if (cfg_we_i) begin
      lcnt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_PLACE;
      layer_q <= '0;
      tex_q   <= '0;
    end else if (cmd_i.capture) begin
      op_q    <= opcode_e'(opcode_i);
      layer_q <= layer_i;
      tex_q   <= tex_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LAYERS; l++) begin
        cur_q[l]     <= '0;
        created_q[l] <= '0;
        slots_q[l]   <= '0;
        units_q[l]   <= '0;
      end
    end else if (cmd_i.clear) begin
      // created batches survive a clear
      for (int l = 0; l < LAYERS; l++) begin
        if (ACW'(l) < active) begin
          cur_q[l]   <= '0;
          slots_q[l] <= '0;
          units_q[l] <= '0;
        end
      end
    end else if (commit_ok) begin
      cur_q[layer_idx]     <= new_batch;
      created_q[layer_idx] <= new_created;
      slots_q[layer_idx]   <= slot + SCW'(1);
      units_q[layer_idx]   <= new_units;
    end
  end

  // one RAM read per cycle while searching, each compared in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      cmp_idx_q <= '0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
    end else begin
      if (cmd_i.capture || cmd_i.search_start) begin
        rd_idx_q <= '0;
        rd_vld_q <= 1'b0;
        hit_q    <= 1'b0;
      end else begin
        rd_vld_q <= issue;
        if (issue) begin
          rd_idx_q  <= rd_idx_q + UCW'(1);
          cmp_idx_q <= rd_idx_q[UIW-1:0];
        end
        if (cmd_i.search && match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx_q;
        end
      end
    end
  end

  sbsa_ram #(
    .WIDTH (TEX_W),
    .DEPTH (DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (base + AW'(unit)),
    .wdata_i (tex_q),
    .re_i    (issue),
    .raddr_i (base + AW'(rd_idx_q[UIW-1:0])),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_batch_q  <= '0;
      res_slot_q   <= '0;
      res_unit_q   <= '0;
      res_made_q   <= 1'b0;
      res_status_q <= ST_PLACED;
    end else if (cmd_i.res_bad) begin
      res_batch_q  <= '0;
      res_slot_q   <= '0;
      res_unit_q   <= '0;
      res_made_q   <= 1'b0;
      res_status_q <= ST_BAD_LAYER;
    end else if (cmd_i.commit) begin
      if (no_batch) begin
        res_batch_q  <= '0;
        res_slot_q   <= '0;
        res_unit_q   <= '0;
        res_made_q   <= 1'b0;
        res_status_q <= ST_NO_BATCH;
      end else begin
        res_batch_q  <= BATCH_OUT_W'(new_batch);
        res_slot_q   <= SLOT_OUT_W'(slot);
        res_unit_q   <= UNIT_OUT_W'(unit);
        res_made_q   <= made;
        res_status_q <= ST_PLACED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_batch_q  <= '0;
      out_slot_q   <= '0;
      out_unit_q   <= '0;
      out_made_q   <= 1'b0;
      out_status_q <= ST_PLACED;
    end else if (cmd_i.out_load) begin
      out_valid_q  <= 1'b1;
      out_batch_q  <= res_batch_q;
      out_slot_q   <= res_slot_q;
      out_unit_q   <= res_unit_q;
      out_made_q   <= res_made_q;
      out_status_q <= res_status_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign batch_o         = out_batch_q;
  assign slot_o          = out_slot_q;
  assign tex_unit_o      = out_unit_q;
  assign batch_created_o = out_made_q;
  assign status_out_o    = out_status_q;

  `SBSA_ASSERT_IMP(a_load_free, cmd_i.out_load, out_free, "result loaded over an unread beat")
  `SBSA_ASSERT_IMP(a_no_wr_in_search, ram_we, !cmd_i.search, "texture RAM written during search")
  `SBSA_ASSERT_NXT(a_slot_counted, commit_ok, slots_q[layer_idx] != '0, "placement not counted")
  `SBSA_ASSERT_IMP(a_cur_below_created, !bad_layer, ((created_rd == '0) && (cur_rd == '0)) || (CRW'(cur_rd) < created_rd), "current batch beyond created batches")

endmodule
